>>> rtl/bm3_pkg.sv
// shared types and constants for the 3x3 box mean stream filter
`default_nettype none
package bm3_pkg;

  localparam int PIX_W    = 8;   // gray pixel
  localparam int CSUM_W   = 10;  // sum of three pixels in one column
  localparam int WSUM_W   = 12;  // sum of the nine pixels in a window
  localparam int ROW_W    = 16;  // row counter and centre row
  localparam int COL_W    = 10;  // centre column field
  localparam int IMG_W_W  = 11;  // image_width register
  localparam int IMG_H_W  = 16;  // image_height register
  localparam int CFG_D_W  = 16;  // configuration write data
  localparam int OUT_D_W  = 40;  // mean, row, col packed and padded to bytes
  localparam int LINE_W   = 2 * PIX_W;  // one line store entry: older and newer pixel

  // floor(s / 9) = (s * DIV9_MUL) >> DIV9_SHIFT, exact for s below 32768
  localparam int DIV9_MUL_W = 13;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
  localparam int DIV9_SHIFT = 16;
  localparam int PROD_W = WSUM_W + DIV9_MUL_W;

  localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd480;
  localparam logic [IMG_H_W-1:0] IMG_H_MIN   = 16'd3;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [CSUM_W-1:0] csum_t;
  typedef logic [WSUM_W-1:0] wsum_t;

endpackage
`default_nettype wire

>>> rtl/box_mean_3x3_stream.sv
// top level of the streaming 3x3 box mean filter
// Takes one 8-bit gray pixel per clock in raster order and, for every pixel that closes a
// full 3x3 window (row and column at least 2), returns floor(window sum / 9) with the
// window centre's row and column; border pixels give no result and out_tlast marks the
// last result of a frame. A new pixel is accepted every clock while the result register
// is free or being taken; a pixel's result passes through stage 1, stage 2 and the result
// register to out_tdata. The two previous rows live in one line store ram (one entry per
// column, read when the pixel is accepted, rewritten when the pixel leaves the first stage),
// so width and column addressing follow MAX_WIDTH. The line store has no reset: the first
// two rows after reset read stale data, but those never reach a result. A stalled out_tready
// holds the whole pipeline.
// Configuration writes (cfg_index 0 image_width, 1 image_height) are taken every clock.
`default_nettype none
module box_mean_3x3_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // pixel [7:0]
  input  wire logic [bm3_pkg::PIX_W-1:0] in_tdata,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // mean_value [7:0], center_row [23:8], center_col [33:24], zero [39:34]
  output logic [bm3_pkg::OUT_D_W-1:0]    out_tdata,
  output logic                           out_tlast,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire bm3_pkg::cfg_idx_t         cfg_index,
  input  wire logic [bm3_pkg::CFG_D_W-1:0] cfg_data
);
  import bm3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int EW = (WW > IMG_W_W) ? WW : IMG_W_W;

  // configuration
  logic [IMG_W_W-1:0] image_width_r;
  logic [IMG_H_W-1:0] image_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMG_W_RESET;
      image_height_r <= IMG_H_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // bounds in use
  logic [EW-1:0]      w_cfg_ext;
  logic [EW-1:0]      w_use_ext;
  logic [WW-1:0]      w_use;
  logic [IMG_H_W-1:0] h_use;

  assign w_cfg_ext = EW'(image_width_r);

  always_comb begin
    if (w_cfg_ext < EW'(3)) begin
      w_use_ext = EW'(3);
    end else if (w_cfg_ext > EW'(MAX_WIDTH)) begin
      w_use_ext = EW'(MAX_WIDTH);
    end else begin
      w_use_ext = w_cfg_ext;
    end
  end

  assign w_use = WW'(w_use_ext);
  assign h_use = (image_height_r < IMG_H_MIN) ? IMG_H_MIN : image_height_r;

  // pipeline advance: everything moves when the result register can take a new entry
  logic adv;
  logic in_acc;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && in_tready;

  // position counters
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    col_eff;
  logic             col_wrap;
  logic             row_wrap;
  logic             emit;
  logic             frame_end;

  always_comb begin
    // a column left past a narrowed width is treated as the last column
    if (WW'(col_r) >= w_use) begin
      col_eff = CW'(w_use - WW'(1));
    end else begin
      col_eff = col_r;
    end
    col_wrap  = WW'(col_eff) == (w_use - WW'(1));
    row_wrap  = row_r >= (h_use - IMG_H_W'(1));
    emit      = (row_r >= ROW_W'(2)) && (WW'(col_eff) >= WW'(2));
    frame_end = (row_r == (h_use - IMG_H_W'(1))) && col_wrap;
    col_nxt   = col_wrap ? '0 : col_eff + CW'(1);
    if (!col_wrap) begin
      row_nxt = row_r;
    end else if (row_wrap) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line store read data arrives, column sum, write back
  logic             s1_v_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [CW-1:0]    s1_addr_r;
  logic             s1_emit_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_tdata;
      s1_addr_r <= col_eff;
      s1_emit_r <= emit;
      s1_row_r  <= row_r - ROW_W'(1);
      s1_col_r  <= COL_W'(EW'(col_eff) - EW'(1));
      s1_last_r <= frame_end;
    end
  end

  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;
  logic              line_we;
  logic [PIX_W-1:0]  rd_newer;
  logic [PIX_W-1:0]  rd_older;

  assign rd_newer = line_rd[PIX_W-1:0];
  assign rd_older = line_rd[LINE_W-1:PIX_W];
  assign line_we  = s1_v_r && adv;
  // newer row moves to older, the pixel becomes newer
  assign line_wr  = {rd_newer, s1_px_r};

  bm3_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_addr_r),
    .wdata (line_wr),
    .re    (in_acc),
    .raddr (col_eff),
    .rdata (line_rd)
  );

  csum_t colsum;
  csum_t mid_out;
  csum_t left_out;
  wsum_t mid_acc;
  wsum_t win_sum;

  assign colsum = CSUM_W'(rd_older) + CSUM_W'(rd_newer) + CSUM_W'(s1_px_r);

  // chain of window cells: mid column, then left column
  bm3_col_cell u_cell_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (line_we),
    .shift_in  (colsum),
    .acc_in    (WSUM_W'(colsum)),
    .shift_out (mid_out),
    .acc_out   (mid_acc)
  );

  bm3_col_cell u_cell_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (line_we),
    .shift_in  (mid_out),
    .acc_in    (mid_acc),
    .shift_out (left_out),
    .acc_out   (win_sum)
  );

  // stage 2: window sum registered ahead of the divide by nine
  logic             s2_v_r;
  wsum_t            s2_sum_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;
  logic             s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sum_r  <= win_sum;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_last_r <= s1_last_r;
    end
  end

  // result register
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  mean_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic              out_last_r;
  logic              out_v_r;

  assign prod = PROD_W'(s2_sum_r) * PROD_W'(DIV9_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mean_r     <= prod[DIV9_SHIFT +: PIX_W];
      out_row_r  <= s2_row_r;
      out_col_r  <= s2_col_r;
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_D_W - PIX_W - ROW_W - COL_W)'(0), out_col_r, out_row_r, mean_r};

`ifndef ASSERT_OFF
  // the write-back never hits the column being read for the next pixel
  a_no_line_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (line_we && in_acc) |-> (s1_addr_r != col_eff))
    else $error("line store read and write at the same column");

  // the frame's last result sits one column in from the right edge
  a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_col_r == COL_W'(EW'(w_use) - EW'(2))))
    else $error("frame end flagged away from the last interior column");

  // a pending window sum is not dropped while the result register is stalled
  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !adv) |=> (s2_v_r && $stable(s2_sum_r)))
    else $error("stage 2 lost its window sum during a stall");
`endif

endmodule
`default_nettype wire

>>> rtl/bm3_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module bm3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/bm3_col_cell.sv
// one window column cell: holds a column sum, shifts it on, adds it into the window sum
`default_nettype none
module bm3_col_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire bm3_pkg::csum_t shift_in,
  input  wire bm3_pkg::wsum_t acc_in,
  output bm3_pkg::csum_t     shift_out,
  output bm3_pkg::wsum_t     acc_out
);
  import bm3_pkg::*;

  csum_t csum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum_r <= '0;
    end else if (en) begin
      csum_r <= shift_in;
    end
  end

  assign shift_out = csum_r;
  assign acc_out   = acc_in + WSUM_W'(csum_r);

endmodule
`default_nettype wire
